[rtl/core/isrm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrm_pkg
// Shared constants, codes and types of the interval statistics rate monitor.
// ----------------------------------------------------------------------------
package isrm_pkg;

	localparam int TICK_W = 32;

	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_FREQ  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_SCALE = 1'b1;

	localparam logic [31:0] FREQ_RESET = 32'd100000000;
	localparam logic [31:0] ALL_ONES   = 32'hffffffff;
	localparam logic [31:0] KILO_DIV   = 32'd1000;
	localparam logic [31:0] MEGA_DIV   = 32'd1000000;

	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_CLEAR  = 1'b1;

	localparam logic SCALE_KILO = 1'b0;
	localparam logic SCALE_MEGA = 1'b1;

	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	localparam int MUL_STEPS = 32;
	localparam int DIV_STEPS = 64;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic        start;
		logic        op;
		logic [63:0] a;
		logic [63:0] b;
	} alu_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] result;
	} alu_rsp_t;

endpackage

[rtl/core/isrm_item_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrm_item_if
// Input channel: one beat carries a record or clear item.
// ----------------------------------------------------------------------------
interface isrm_item_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] start_tick;
	logic [31:0] end_tick;

	modport source (output valid, output func, output start_tick, output end_tick,
		input ready);
	modport sink (input valid, input func, input start_tick, input end_tick,
		output ready);
endinterface

[rtl/core/isrm_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrm_result_if
// Output channel: one beat carries the statistics after an item.
// ----------------------------------------------------------------------------
interface isrm_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] sample_count;
	logic [31:0] min_interval;
	logic [31:0] max_interval;
	logic [31:0] avg_rate;
	logic [31:0] min_rate;
	logic [31:0] max_rate;
	logic        rate_valid;

	modport source (output valid, output sample_count, output min_interval,
		output max_interval, output avg_rate, output min_rate, output max_rate,
		output rate_valid, input ready);
	modport sink (input valid, input sample_count, input min_interval,
		input max_interval, input avg_rate, input min_rate, input max_rate,
		input rate_valid, output ready);
endinterface

[rtl/core/isrm_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isrm_alu
// Shared iterative unit: shift-add multiply (64 x 32, modulo 2^64) and
// restoring divide (64 / 64), one bit per cycle.
// ----------------------------------------------------------------------------
module isrm_alu import isrm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             op_q;
	logic [63:0]      acc_q;
	logic [63:0]      mc_q;
	logic [63:0]      mp_q;

	logic [64:0] rem_shift;
	logic [65:0] diff;
	logic        ge;
	logic [63:0] rem_next;

	assign rem_shift = {acc_q, mp_q[63]};
	assign diff      = {1'b0, rem_shift} - {2'b00, mc_q};
	assign ge        = ~diff[65];
	assign rem_next  = ge ? diff[63:0] : rem_shift[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == OP_MUL) ? CNT_W'(MUL_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			acc_q <= '0;
			if (req.op == OP_MUL) begin
				mc_q <= req.a;
				mp_q <= {32'b0, req.b[31:0]};
			end else begin
				mc_q <= req.b;
				mp_q <= req.a;
			end
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				acc_q <= acc_q + (mp_q[0] ? mc_q : 64'd0);
				mc_q  <= {mc_q[62:0], 1'b0};
				mp_q  <= {1'b0, mp_q[63:1]};
			end else begin
				acc_q <= rem_next;
				mp_q  <= {mp_q[62:0], ge};
			end
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = (op_q == OP_MUL) ? acc_q : mp_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("isrm_alu: start while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("isrm_alu: done without a running operation");
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("isrm_alu: done while still busy");
`endif

endmodule

[rtl/core/interval_stats_rate_monitor_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_stats_rate_monitor_unit
// Interval latency and throughput monitor with running count, minimum,
// maximum and rounded rate outputs.
// ----------------------------------------------------------------------------
// A record item with a nonzero span takes its rates from nine operations on
// one shared shift-add / shift-subtract unit: six multiplies of 32 steps and
// three divides of 64 steps, each passing the issue and wait states. A clear
// item, or a record that leaves the span at zero, goes from the check state
// straight to the finish state. One item is worked on at a time; the next
// item is taken as soon as the previous result sits in the output register,
// even while that result still waits to be taken.
module interval_stats_rate_monitor_unit import isrm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	isrm_item_if.sink         item,
	isrm_result_if.source     result
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_ISSUE = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	localparam logic [3:0] ST_BASE     = 4'd0;
	localparam logic [3:0] ST_AVG_MUL  = 4'd1;
	localparam logic [3:0] ST_AVG_DIV  = 4'd2;
	localparam logic [3:0] ST_MIN_MUL0 = 4'd3;
	localparam logic [3:0] ST_MIN_MUL1 = 4'd4;
	localparam logic [3:0] ST_MIN_DIV  = 4'd5;
	localparam logic [3:0] ST_MAX_MUL0 = 4'd6;
	localparam logic [3:0] ST_MAX_MUL1 = 4'd7;
	localparam logic [3:0] ST_MAX_DIV  = 4'd8;

	logic [31:0] freq_q;
	logic        scale_q;

	logic [63:0]       busy_q;
	logic [63:0]       span_q;
	logic [TICK_W-1:0] prev_end_q;
	logic [31:0]       count_q;
	logic [31:0]       longest_q;
	logic [31:0]       shortest_q;

	logic [2:0] state_q;
	logic [3:0] step_q;

	logic [63:0] base_q;
	logic [63:0] num_q;
	logic [31:0] avg_q;
	logic [31:0] min_q;
	logic [31:0] max_q;
	logic        valid_q;

	logic        res_valid_q;
	logic [31:0] out_count_q;
	logic [31:0] out_min_iv_q;
	logic [31:0] out_max_iv_q;
	logic [31:0] out_avg_q;
	logic [31:0] out_min_q;
	logic [31:0] out_max_q;
	logic        out_rv_q;

	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;
	logic                 accept;
	logic [TICK_W-1:0]    iv;
	logic [TICK_W-1:0]    gap;
	logic [31:0]          iv32;
	logic [63:0]          dividend;
	logic [31:0]          quot;
	logic                 out_free;

	alu_req_t req;
	alu_rsp_t rsp;

	isrm_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign pready  = 1'b1;
	assign cfg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		case (cfg_idx)
			REG_FREQ:  prdata = freq_q;
			REG_SCALE: prdata = {31'b0, scale_q};
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q  <= FREQ_RESET;
			scale_q <= SCALE_KILO;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_FREQ:  freq_q  <= pwdata;
				REG_SCALE: scale_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign iv         = item.end_tick[TICK_W-1:0] - item.start_tick[TICK_W-1:0];
	assign gap        = item.end_tick[TICK_W-1:0] - prev_end_q;
	assign iv32       = 32'(iv);
	assign dividend   = num_q + {1'b0, base_q[63:1]};
	assign quot       = (base_q == 64'd0) ? 32'd0 : rsp.result[31:0];
	assign out_free   = !res_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= '0;
			span_q     <= '0;
			prev_end_q <= '0;
			count_q    <= '0;
			longest_q  <= '0;
			shortest_q <= ALL_ONES;
		end else if (accept) begin
			if (item.func == FUNC_CLEAR) begin
				busy_q     <= '0;
				span_q     <= '0;
				prev_end_q <= '0;
				count_q    <= '0;
				longest_q  <= '0;
				shortest_q <= ALL_ONES;
			end else begin
				span_q     <= (busy_q != 64'd0) ? span_q + 64'(gap) : 64'(iv);
				prev_end_q <= item.end_tick[TICK_W-1:0];
				count_q    <= count_q + 32'd1;
				busy_q     <= busy_q + 64'(iv);
				if (longest_q < iv32) begin
					longest_q <= iv32;
				end
				if (shortest_q > iv32) begin
					shortest_q <= iv32;
				end
			end
		end
	end

	always_comb begin
		req       = '0;
		req.start = (state_q == S_ISSUE);
		case (step_q)
			ST_BASE: begin
				req.op = OP_MUL;
				req.a  = span_q;
				req.b  = {32'b0, (scale_q == SCALE_MEGA) ? MEGA_DIV : KILO_DIV};
			end
			ST_AVG_MUL: begin
				req.op = OP_MUL;
				req.a  = busy_q;
				req.b  = {32'b0, freq_q};
			end
			ST_MIN_MUL0: begin
				req.op = OP_MUL;
				req.a  = {32'b0, shortest_q};
				req.b  = {32'b0, freq_q};
			end
			ST_MAX_MUL0: begin
				req.op = OP_MUL;
				req.a  = {32'b0, longest_q};
				req.b  = {32'b0, freq_q};
			end
			ST_MIN_MUL1, ST_MAX_MUL1: begin
				req.op = OP_MUL;
				req.a  = num_q;
				req.b  = {32'b0, count_q};
			end
			ST_AVG_DIV, ST_MIN_DIV, ST_MAX_DIV: begin
				req.op = OP_DIV;
				req.a  = dividend;
				req.b  = base_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_BASE;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					step_q  <= ST_BASE;
					state_q <= (span_q == 64'd0) ? S_FIN : S_ISSUE;
				end
				S_ISSUE: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (rsp.done) begin
						step_q  <= step_q + 4'd1;
						state_q <= (step_q == ST_MAX_DIV) ? S_FIN : S_ISSUE;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			valid_q <= (span_q != 64'd0);
			avg_q   <= '0;
			min_q   <= '0;
			max_q   <= '0;
		end
		if (state_q == S_WAIT && rsp.done) begin
			case (step_q)
				ST_BASE:    base_q <= rsp.result;
				ST_AVG_DIV: avg_q  <= quot;
				ST_MIN_DIV: min_q  <= quot;
				ST_MAX_DIV: max_q  <= quot;
				default:    num_q  <= rsp.result;
			endcase
		end
		if (state_q == S_FIN && out_free) begin
			out_count_q  <= count_q;
			out_min_iv_q <= shortest_q;
			out_max_iv_q <= longest_q;
			out_avg_q    <= avg_q;
			out_min_q    <= min_q;
			out_max_q    <= max_q;
			out_rv_q     <= valid_q;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.sample_count = out_count_q;
	assign result.min_interval = out_min_iv_q;
	assign result.max_interval = out_max_iv_q;
	assign result.avg_rate     = out_avg_q;
	assign result.min_rate     = out_min_q;
	assign result.max_rate     = out_max_q;
	assign result.rate_valid   = out_rv_q;

`ifndef SYNTHESIS
	a_alu_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.busy |-> state_q == S_WAIT)
		else $error("isrm: shared unit running outside the wait state");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_CHECK)
		else $error("isrm: accepted beat did not start the sequence");
	a_zero_span_rates: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !out_rv_q |-> out_avg_q == 32'd0 && out_min_q == 32'd0
			&& out_max_q == 32'd0)
		else $error("isrm: rates nonzero with zero span");
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 32'd0 |-> shortest_q <= longest_q)
		else $error("isrm: minimum interval above maximum");
`endif

endmodule
